@@ hw/rtl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants, command codes and controller/datapath interface types
// for the bitstream reader with start code scanning.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // ring store geometry
    localparam int BUF_BYTES = 4096;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int HELD_W    = $clog2(BUF_BYTES + 1);
    localparam int WIN_BYTES = 5;

    localparam logic [ADDR_W:0] RING_SIZE = (ADDR_W + 1)'(BUF_BYTES);

    // stream constants
    localparam logic [7:0]  CODE_MARK = 8'h01;
    localparam logic [7:0]  SYNC_BYTE = 8'hff;
    localparam logic [7:0]  SYNC_MASK = 8'hfe;
    localparam logic [7:0]  SYNC_LOW  = 8'hfc;
    localparam logic [31:0] NO_CODE   = 32'hffffffff;
    localparam logic [5:0]  MAX_BITS  = 6'd32;

    // commands of one input transaction
    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_READ  = 4'd1,
        CMD_SKIP  = 4'd2,
        CMD_ALIGN = 4'd3,
        CMD_PEEK  = 4'd4,
        CMD_FILL  = 4'd5,
        CMD_NEXT  = 4'd6,
        CMD_FIND  = 4'd7,
        CMD_PROBE = 4'd8,
        CMD_SYNC  = 4'd9
    } cmd_t;

    // read position movements
    typedef enum logic [2:0] {
        MV_NONE,
        MV_PUSH,
        MV_ALIGN,
        MV_STEP,
        MV_CODE,
        MV_SYNC,
        MV_BITS,
        MV_RESTORE
    } mv_t;

    // result value selection
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_ONES,
        RES_BITS,
        RES_PEEK,
        RES_COUNT,
        RES_CODE
    } res_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic run;
        cmd_t op;
        mv_t  mv;
        logic count_inc;
        logic finish;
        res_t res_sel;
        logic ok;
    } dp_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic push_ok;
        logic bits_ok;
        logic avail_ok;
        logic held_ok;
        logic match;
        logic code_eq;
    } dp_stat_t;

    // ring address plus a small increment, wrapped at the ring size
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [2:0] inc);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {{(ADDR_W - 2){1'b0}}, inc};
        if (s >= RING_SIZE)
        begin
            s = s - RING_SIZE;
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/bsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsr_ctrl
// Command sequencer: accepts transactions, steers the datapath through
// fetch and scan steps and owns the result valid flag.
// ----------------------------------------------------------------------------
module bsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        command,
    output logic              out_valid,
    input  logic              out_ready,
    input  bsr_pkg::dp_stat_t stat,
    output bsr_pkg::dp_ctl_t  ctl
);
    import bsr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    cmd_t   cmd_in;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // next state and datapath commands
    always_comb
    begin
        cmd_in         = cmd_t'(command);
        out_free       = !out_valid_reg || out_ready;
        in_ready       = (state_reg == ST_IDLE) && out_free;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ctl            = '0;
        ctl.op         = (state_reg == ST_IDLE) ? cmd_in : cmd_reg;
        ctl.mv         = MV_NONE;
        ctl.res_sel    = RES_ZERO;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    ctl.start = 1'b1;
                    cmd_next  = cmd_in;
                    case (cmd_in)
                        CMD_PUSH:
                        begin
                            ctl.finish = 1'b1;
                            ctl.ok     = stat.push_ok;
                            ctl.mv     = stat.push_ok ? MV_PUSH : MV_NONE;
                        end
                        CMD_READ, CMD_SKIP, CMD_PEEK:
                        begin
                            if (stat.bits_ok)
                            begin
                                state_next = ST_BUSY;
                            end
                            else
                            begin
                                ctl.finish = 1'b1;
                            end
                        end
                        CMD_ALIGN:
                        begin
                            ctl.mv     = MV_ALIGN;
                            ctl.finish = 1'b1;
                            ctl.ok     = 1'b1;
                        end
                        CMD_FILL, CMD_NEXT, CMD_FIND, CMD_PROBE, CMD_SYNC:
                        begin
                            ctl.mv     = MV_ALIGN;
                            state_next = ST_BUSY;
                        end
                        default:
                        begin
                            ctl.finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_BUSY:
            begin
                ctl.run = 1'b1;
                case (cmd_reg)
                    // bit reads wait for the bytes they span
                    CMD_READ, CMD_SKIP, CMD_PEEK:
                    begin
                        if (stat.avail_ok && out_free)
                        begin
                            ctl.finish = 1'b1;
                            ctl.ok     = 1'b1;
                            state_next = ST_IDLE;
                            case (cmd_reg)
                                CMD_READ:
                                begin
                                    ctl.mv      = MV_BITS;
                                    ctl.res_sel = RES_BITS;
                                end
                                CMD_SKIP:
                                begin
                                    ctl.mv = MV_BITS;
                                end
                                default:
                                begin
                                    ctl.res_sel = RES_PEEK;
                                end
                            endcase
                        end
                    end
                    // byte scans advance one position per step
                    CMD_FILL, CMD_NEXT, CMD_FIND, CMD_PROBE, CMD_SYNC:
                    begin
                        if (!stat.held_ok)
                        begin
                            if (out_free)
                            begin
                                ctl.finish = 1'b1;
                                state_next = ST_IDLE;
                                case (cmd_reg)
                                    CMD_FILL:
                                    begin
                                        ctl.ok      = 1'b1;
                                        ctl.res_sel = RES_COUNT;
                                    end
                                    CMD_SYNC:
                                    begin
                                        ctl.res_sel = RES_ZERO;
                                    end
                                    CMD_PROBE:
                                    begin
                                        ctl.mv      = MV_RESTORE;
                                        ctl.res_sel = RES_ONES;
                                    end
                                    default:
                                    begin
                                        ctl.res_sel = RES_ONES;
                                    end
                                endcase
                            end
                        end
                        else if (stat.avail_ok)
                        begin
                            if (stat.match)
                            begin
                                case (cmd_reg)
                                    CMD_FILL:
                                    begin
                                        ctl.mv        = MV_STEP;
                                        ctl.count_inc = 1'b1;
                                    end
                                    CMD_SYNC:
                                    begin
                                        if (out_free)
                                        begin
                                            ctl.mv     = MV_SYNC;
                                            ctl.finish = 1'b1;
                                            ctl.ok     = 1'b1;
                                            state_next = ST_IDLE;
                                        end
                                    end
                                    CMD_NEXT:
                                    begin
                                        if (out_free)
                                        begin
                                            ctl.mv      = MV_CODE;
                                            ctl.finish  = 1'b1;
                                            ctl.ok      = 1'b1;
                                            ctl.res_sel = RES_CODE;
                                            state_next  = ST_IDLE;
                                        end
                                    end
                                    default:
                                    begin
                                        // find and probe: skip codes that differ
                                        if (!stat.code_eq)
                                        begin
                                            ctl.mv = MV_CODE;
                                        end
                                        else if (out_free)
                                        begin
                                            ctl.mv      = (cmd_reg == CMD_PROBE) ?
                                                          MV_RESTORE : MV_CODE;
                                            ctl.finish  = 1'b1;
                                            ctl.ok      = 1'b1;
                                            ctl.res_sel = RES_CODE;
                                            state_next  = ST_IDLE;
                                        end
                                    end
                                endcase
                            end
                            else if (cmd_reg == CMD_FILL)
                            begin
                                if (out_free)
                                begin
                                    ctl.finish  = 1'b1;
                                    ctl.ok      = 1'b1;
                                    ctl.res_sel = RES_COUNT;
                                    state_next  = ST_IDLE;
                                end
                            end
                            else
                            begin
                                ctl.mv = MV_STEP;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = ctl.finish || (out_valid_reg && !out_ready);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/bsr_dpath.sv @@
// ----------------------------------------------------------------------------
// bsr_dpath
// Byte ring store, read/write pointers, five byte fetch window, bit
// extraction, pattern compares and the result register.
// ----------------------------------------------------------------------------
module bsr_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  bsr_pkg::dp_ctl_t  ctl,
    output bsr_pkg::dp_stat_t stat,
    input  logic [7:0]        byte_in,
    input  logic [5:0]        bit_count,
    input  logic [7:0]        fill_value,
    input  logic [7:0]        target_code,
    output logic [31:0]       result_value,
    output logic              success,
    output logic [15:0]       bits_buffered
);
    import bsr_pkg::*;

    // ring store and its registered read port
    logic [7:0]        mem [BUF_BYTES];
    logic [7:0]        rdata_reg;
    logic              pend_reg, pend_next;
    logic              issue;
    logic [ADDR_W-1:0] issue_addr;

    // pointers
    logic [ADDR_W-1:0] pos_byte_reg, pos_byte_next;
    logic [2:0]        pos_off_reg, pos_off_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] save_byte_reg;
    logic [2:0]        save_off_reg;
    logic [HELD_W-1:0] save_held_reg;

    // fetch window
    logic [7:0]        win_reg [WIN_BYTES];
    logic [7:0]        win_next [WIN_BYTES];
    logic [7:0]        view [WIN_BYTES];
    logic [2:0]        have_reg, have_next;
    logic [2:0]        avail;
    logic [2:0]        need;
    logic [HELD_W-1:0] thresh;
    logic              flush;
    logic              shift;

    // operands of the transaction in progress
    logic [5:0]        n_reg;
    logic [5:0]        n_sel;
    logic [7:0]        fill_reg;
    logic [7:0]        target_reg;
    logic [HELD_W-1:0] count_reg, count_next;

    // arithmetic
    logic [HELD_W+2:0] avail_bits;
    logic [6:0]        need_sum;
    logic [5:0]        amount;
    logic [6:0]        tot;
    logic [2:0]        freed;
    logic [39:0]       v40;
    logic [39:0]       v40_sh;
    logic [31:0]       bits_val;
    logic [31:0]       res_value;

    // result register
    logic [31:0]       out_value_reg;
    logic              out_ok_reg;
    logic [15:0]       out_bits_reg;

    // window view with the byte just read appended
    always_comb
    begin
        avail = have_reg + {2'b00, pend_reg};
        for (int i = 0; i < WIN_BYTES; i++)
        begin
            view[i] = (3'(i) < have_reg) ? win_reg[i] : rdata_reg;
        end
    end

    // bytes needed and bytes that must be held for the current command
    always_comb
    begin
        n_sel    = ctl.start ? bit_count : n_reg;
        need_sum = 7'(pos_off_reg) + 7'(n_sel) + 7'd7;
        case (ctl.op)
            CMD_READ, CMD_SKIP, CMD_PEEK:
            begin
                need   = need_sum[5:3];
                thresh = '0;
            end
            CMD_NEXT, CMD_FIND, CMD_PROBE:
            begin
                need   = 3'd4;
                thresh = HELD_W'(5);
            end
            CMD_SYNC:
            begin
                need   = 3'd2;
                thresh = HELD_W'(2);
            end
            CMD_FILL:
            begin
                need   = 3'd1;
                thresh = HELD_W'(1);
            end
            default:
            begin
                need   = 3'd0;
                thresh = '0;
            end
        endcase
    end

    // status towards the controller
    always_comb
    begin
        avail_bits    = {held_reg, 3'b000} - {{HELD_W{1'b0}}, pos_off_reg};
        stat.push_ok  = held_reg < HELD_W'(BUF_BYTES);
        stat.bits_ok  = (bit_count <= MAX_BITS) &&
                        ({{(HELD_W - 3){1'b0}}, bit_count} <= avail_bits);
        stat.avail_ok = avail >= need;
        stat.held_ok  = held_reg >= thresh;
        stat.code_eq  = view[3] == target_reg;
        case (ctl.op)
            CMD_NEXT, CMD_FIND, CMD_PROBE:
                stat.match = (view[0] == 8'h00) && (view[1] == 8'h00) &&
                             (view[2] == CODE_MARK);
            CMD_SYNC:
                stat.match = (view[0] == SYNC_BYTE) &&
                             ((view[1] & SYNC_MASK) == SYNC_LOW);
            CMD_FILL:
                stat.match = view[0] == fill_reg;
            default:
                stat.match = 1'b0;
        endcase
    end

    // read position movement
    always_comb
    begin
        case (ctl.mv)
            MV_ALIGN: amount = (pos_off_reg == 3'd0) ? 6'd0 : 6'(4'd8 - {1'b0, pos_off_reg});
            MV_STEP:  amount = 6'd8;
            MV_CODE:  amount = 6'd32;
            MV_SYNC:  amount = 6'd11;
            MV_BITS:  amount = n_reg;
            default:  amount = 6'd0;
        endcase
        tot   = {4'b0000, pos_off_reg} + {1'b0, amount};
        freed = tot[5:3];

        pos_byte_next = pos_byte_reg;
        pos_off_next  = pos_off_reg;
        held_next     = held_reg;
        wr_ptr_next   = wr_ptr_reg;
        case (ctl.mv)
            MV_PUSH:
            begin
                wr_ptr_next = wrap_add(wr_ptr_reg, 3'd1);
                held_next   = held_reg + HELD_W'(1);
            end
            MV_ALIGN, MV_STEP, MV_CODE, MV_SYNC, MV_BITS:
            begin
                pos_byte_next = wrap_add(pos_byte_reg, freed);
                pos_off_next  = tot[2:0];
                held_next     = held_reg - {{(HELD_W - 3){1'b0}}, freed};
            end
            MV_RESTORE:
            begin
                pos_byte_next = save_byte_reg;
                pos_off_next  = save_off_reg;
                held_next     = save_held_reg;
            end
            default:
            begin
                pos_byte_next = pos_byte_reg;
            end
        endcase
    end

    // window update and byte fetch
    always_comb
    begin
        flush = ctl.start || ctl.finish || (ctl.mv == MV_CODE);
        shift = ctl.mv == MV_STEP;
        for (int i = 0; i < WIN_BYTES - 1; i++)
        begin
            win_next[i] = shift ? view[i + 1] : view[i];
        end
        win_next[WIN_BYTES-1] = shift ? rdata_reg : view[WIN_BYTES-1];
        have_next  = flush ? 3'd0 : (avail - {2'b00, shift});
        issue      = (ctl.start || ctl.run) && !ctl.finish && (ctl.mv != MV_CODE) &&
                     (have_next < need);
        issue_addr = wrap_add(pos_byte_next, have_next);
        pend_next  = issue;
        count_next = ctl.start ? '0 : (count_reg + {{(HELD_W - 1){1'b0}}, ctl.count_inc});
    end

    // bit extraction and result selection
    always_comb
    begin
        v40      = {view[0], view[1], view[2], view[3], view[4]};
        v40_sh   = v40 << pos_off_reg;
        bits_val = v40_sh[39:8] >> (MAX_BITS - n_reg);
        case (ctl.res_sel)
            RES_ONES:  res_value = NO_CODE;
            RES_BITS:  res_value = bits_val;
            RES_PEEK:  res_value = {31'd0, |bits_val};
            RES_COUNT: res_value = 32'(count_reg);
            RES_CODE:  res_value = {24'd0, view[3]};
            default:   res_value = '0;
        endcase
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.mv == MV_PUSH)
        begin
            mem[wr_ptr_reg] <= byte_in;
        end
        if (issue)
        begin
            rdata_reg <= mem[issue_addr];
        end
    end

    // pointer and window control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_byte_reg <= '0;
            pos_off_reg  <= '0;
            held_reg     <= '0;
            wr_ptr_reg   <= '0;
            have_reg     <= '0;
            pend_reg     <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            pos_byte_reg <= pos_byte_next;
            pos_off_reg  <= pos_off_next;
            held_reg     <= held_next;
            wr_ptr_reg   <= wr_ptr_next;
            have_reg     <= have_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
        end
    end

    // window bytes, operands, saved position and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_BYTES; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        if (ctl.start)
        begin
            n_reg         <= bit_count;
            fill_reg      <= fill_value;
            target_reg    <= target_code;
            save_byte_reg <= pos_byte_reg;
            save_off_reg  <= pos_off_reg;
            save_held_reg <= held_reg;
        end
        if (ctl.finish)
        begin
            out_value_reg <= res_value;
            out_ok_reg    <= ctl.ok;
            out_bits_reg  <= 16'({held_next, 3'b000} - {{HELD_W{1'b0}}, pos_off_next});
        end
    end

    assign result_value  = out_value_reg;
    assign success       = out_ok_reg;
    assign bits_buffered = out_bits_reg;

endmodule

@@ hw/rtl/bitstream_reader_start_code_scan_top.sv @@
// ----------------------------------------------------------------------------
// bitstream_reader_start_code_scan_top
// Stream bytes are pushed into a 4096 byte ring and consumed MSB first by
// commands, one result transaction per command transaction. Push, align,
// unused codes and bit requests that fail the length check finish in the
// accept cycle, so the result is valid on the next clock. Read, skip and peek
// fetch the bytes the request spans through the single read port of the byte
// store, one byte per cycle. Scans (skip fill, next code, find code, probe
// code, frame sync) first fill a window of up to four bytes, one per cycle,
// and then step one byte per cycle; find and probe refill the window after
// every start code that does not match. Only one command is in progress at
// a time; a finished result waits in an output register, and the next
// command is accepted once that register is free or being emptied. The
// store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module bitstream_reader_start_code_scan_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [7:0]  byte_in,
    input  logic [5:0]  bit_count,
    input  logic [7:0]  fill_value,
    input  logic [7:0]  target_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        success,
    output logic [15:0] bits_buffered
);
    import bsr_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    // command sequencer
    bsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // store, pointers and result register
    bsr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .byte_in       (byte_in),
        .bit_count     (bit_count),
        .fill_value    (fill_value),
        .target_code   (target_code),
        .result_value  (result_value),
        .success       (success),
        .bits_buffered (bits_buffered)
    );

endmodule

@@ hw/rtl/bsr_checker.sv @@
// ----------------------------------------------------------------------------
// bsr_checker
// Port level checks on the bitstream reader, attached to the top level by
// a bind statement.
// ----------------------------------------------------------------------------
module bsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [3:0]  command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic        success,
    input logic [15:0] bits_buffered
);
    import bsr_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) &&
                                    $stable(success) && $stable(bits_buffered))
        else $error("result changed while stalled");

    // an accepted transaction either yields a result or keeps the input closed
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid || !in_ready)
        else $error("new command taken before previous one finished");

    // no command is taken while a result is stuck in the output register
    a_out_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("command accepted with output register blocked");

    // a push answers on the next clock with a zero value
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_PUSH) |=>
            out_valid && (result_value == 32'd0))
        else $error("push result missing or non-zero");

endmodule

bind bitstream_reader_start_code_scan_top bsr_checker u_bsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .success       (success),
    .bits_buffered (bits_buffered)
);
